/* hdl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the RGB median filter
// Pixel and register widths, register indexes, controller command and
// status groups.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int HIST_AW   = 8;
    localparam int HIST_D    = 256;
    localparam int CNT_W     = 8;
    localparam int SCAN_W    = 9;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic ACT_PIXEL        = 1'b0;
    localparam logic ACT_DRAIN        = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic px_write;
        logic win_init;
        logic store_rd;
        logic hist_rd;
        logic hist_inc;
        logic scan_step;
        logic emit_done;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic loaded;
        logic want_emit;
        logic win_empty;
        logic elem_last;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

/* hdl/rgb_median_filter_15x15.sv */
// A word that yields a result runs the gather of N window pixels, N being the
// window size (64 at a corner, 225 inside), then the bin scan and the hand-off.
// One word at a time, set by the serial histogram build (a read and an increment
// step per window pixel, a read and a write port per histogram) and the bin scan.
// Reset: synchronous, active low; a clear of all 256 histogram bins follows reset,
// during which no word is accepted.
// ----------------------------------------------------------------------------
// rgb_median_filter_15x15: streaming per-channel 2D median filter
// Raster RGB pixels in, window medians out, drain words flush the frame.
// ----------------------------------------------------------------------------
module rgb_median_filter_15x15 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int RADIUS     = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [rmf_pkg::PIX_W-1:0] s_red_in,
    input  logic [rmf_pkg::PIX_W-1:0] s_green_in,
    input  logic [rmf_pkg::PIX_W-1:0] s_blue_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rmf_pkg::PIX_W-1:0] m_red_out,
    output logic [rmf_pkg::PIX_W-1:0] m_green_out,
    output logic [rmf_pkg::PIX_W-1:0] m_blue_out,
    output logic                      m_frame_last
);
    import rmf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    rmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath
    rmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RADIUS     (RADIUS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_frame_last (m_frame_last)
    );

endmodule

/* hdl/rmf_ram.sv */
// ----------------------------------------------------------------------------
// rmf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rmf_ctrl.sv */
// ----------------------------------------------------------------------------
// rmf_ctrl: sequencer of the median filter
// Steps the histogram clear, pixel store, window gather, median scan and
// result hand-off.
// ----------------------------------------------------------------------------
module rmf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_action,
    output rmf_pkg::cmd_t cmd,
    input  rmf_pkg::stat_t stat
);
    import rmf_pkg::*;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_WIN  = 4'd3;
    localparam logic [3:0] ST_RD   = 4'd4;
    localparam logic [3:0] ST_HR   = 4'd5;
    localparam logic [3:0] ST_HW   = 4'd6;
    localparam logic [3:0] ST_SCAN = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_PIXEL && !stat.loaded) begin
                        cmd.px_write = 1'b1;
                        state_next   = ST_CHK;
                    end else if (s_action == ACT_DRAIN && stat.loaded) begin
                        state_next = ST_WIN;
                    end
                end
            end
            ST_CHK: begin
                state_next = stat.want_emit ? ST_WIN : ST_IDLE;
            end
            ST_WIN: begin
                cmd.win_init = 1'b1;
                state_next   = stat.win_empty ? ST_SCAN : ST_RD;
            end
            ST_RD: begin
                cmd.store_rd = 1'b1;
                state_next   = ST_HR;
            end
            ST_HR: begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_HW;
            end
            ST_HW: begin
                cmd.hist_inc = 1'b1;
                if (stat.elem_last) begin
                    state_next = ST_SCAN;
                end else begin
                    cmd.store_rd = 1'b1;
                    state_next   = ST_HR;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/rmf_datapath.sv */
// ----------------------------------------------------------------------------
// rmf_datapath: storage, counters and histogram median of the filter
// Holds the line store, frame positions, window iterator, three channel
// histograms, median scan and the output register.
// ----------------------------------------------------------------------------
module rmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int RADIUS     = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [rmf_pkg::CFG_W-1:0]   cfg_data,
    input  logic [rmf_pkg::PIX_W-1:0]   s_red_in,
    input  logic [rmf_pkg::PIX_W-1:0]   s_green_in,
    input  logic [rmf_pkg::PIX_W-1:0]   s_blue_in,
    input  rmf_pkg::cmd_t               cmd,
    output rmf_pkg::stat_t              stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rmf_pkg::PIX_W-1:0]   m_red_out,
    output logic [rmf_pkg::PIX_W-1:0]   m_green_out,
    output logic [rmf_pkg::PIX_W-1:0]   m_blue_out,
    output logic                        m_frame_last
);
    import rmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = (2 * RADIUS + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int BW    = $clog2(RADIUS + 1);
    localparam int SW    = 3 * PIX_W;

    // configuration
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0]    w;
    logic [RW-1:0]    h;

    // frame positions
    logic [RW-1:0] in_row_reg, out_row_reg, out_row_n;
    logic [CW-1:0] in_col_reg, out_col_reg, out_col_n;
    logic [AW-1:0] in_base_reg, out_base_reg;
    logic [PW-1:0] pend_reg;
    logic          loaded_reg;
    logic [PW-1:0] lag;

    // window iterator
    logic [RW-1:0] iter_row_reg, r1_reg, r0, r1;
    logic [CW-1:0] iter_col_reg, c0_reg, c1_reg, c0, c1;
    logic [AW-1:0] row_addr_reg, row_addr_init, elem_addr, wr_addr, row_addr_adv;
    logic [AW-1:0] out_base_adv, in_base_adv;
    logic [BW-1:0] back;
    logic [AW-1:0] back_sub;
    logic          elem_last_reg;
    logic [CNT_W-1:0] count_reg;

    // histograms and scan
    logic [HIST_AW-1:0] clr_idx_reg;
    logic [SCAN_W-1:0]  scan_idx_reg;
    logic [SW-1:0]      store_rdata;
    logic [PIX_W-1:0]   byte_reg  [3];
    logic [CNT_W-1:0]   acc_reg   [3];
    logic [PIX_W-1:0]   med_reg   [3];
    logic               found_reg [3];
    logic [CNT_W-1:0]   hist_rdata [3];
    logic [HIST_AW-1:0] hist_raddr [3];
    logic [HIST_AW-1:0] hist_waddr [3];
    logic [CNT_W-1:0]   hist_wdata [3];
    logic               hist_we, hist_re;

    // output register
    logic             m_valid_reg, m_last_reg;
    logic [PIX_W-1:0] m_pix_reg [3];

    // effective frame size
    always_comb begin
        if (frame_width_reg == '0) w = CW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH) w = CW'(MAX_WIDTH);
        else w = CW'(frame_width_reg);
        if (frame_height_reg == '0) h = RW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
        else h = RW'(frame_height_reg);
    end

    assign lag = PW'(32'(RADIUS) * 32'(w) + 32'(RADIUS));

    // window bounds around the output position
    always_comb begin
        logic [RW:0] rs, rmax;
        logic [CW:0] cs, cmax;
        r0   = (out_row_reg >= RW'(RADIUS)) ? out_row_reg - RW'(RADIUS) : '0;
        c0   = (out_col_reg >= CW'(RADIUS)) ? out_col_reg - CW'(RADIUS) : '0;
        rs   = (RW+1)'(out_row_reg) + (RW+1)'(RADIUS);
        rmax = (RW+1)'(h) - (RW+1)'(1);
        cs   = (CW+1)'(out_col_reg) + (CW+1)'(RADIUS);
        cmax = (CW+1)'(w) - (CW+1)'(1);
        r1   = (rs > rmax) ? RW'(rmax) : RW'(rs);
        c1   = (cs > cmax) ? CW'(cmax) : CW'(cs);
        back = BW'(out_row_reg - r0);
        back_sub = AW'(32'(back) * 32'(w));
    end

    // modular store addresses
    always_comb begin
        logic [AW:0] ea, wa, ra, ob, ib, ri;
        ea = (AW+1)'(row_addr_reg) + (AW+1)'(iter_col_reg);
        elem_addr = (ea >= (AW+1)'(DEPTH)) ? AW'(ea - (AW+1)'(DEPTH)) : AW'(ea);
        wa = (AW+1)'(in_base_reg) + (AW+1)'(in_col_reg);
        wr_addr = (wa >= (AW+1)'(DEPTH)) ? AW'(wa - (AW+1)'(DEPTH)) : AW'(wa);
        ra = (AW+1)'(row_addr_reg) + (AW+1)'(w);
        row_addr_adv = (ra >= (AW+1)'(DEPTH)) ? AW'(ra - (AW+1)'(DEPTH)) : AW'(ra);
        ob = (AW+1)'(out_base_reg) + (AW+1)'(w);
        out_base_adv = (ob >= (AW+1)'(DEPTH)) ? AW'(ob - (AW+1)'(DEPTH)) : AW'(ob);
        ib = (AW+1)'(in_base_reg) + (AW+1)'(w);
        in_base_adv = (ib >= (AW+1)'(DEPTH)) ? AW'(ib - (AW+1)'(DEPTH)) : AW'(ib);
        ri = (AW+1)'(out_base_reg) + (AW+1)'(DEPTH) - (AW+1)'(back_sub);
        row_addr_init = (out_base_reg >= back_sub) ? out_base_reg - back_sub
                                                   : AW'(ri);
    end

    // next output position
    always_comb begin
        out_col_n = out_col_reg + CW'(1);
        out_row_n = out_row_reg;
        if (out_col_n >= w) begin
            out_col_n = '0;
            out_row_n = out_row_reg + RW'(1);
        end
    end

    // status
    assign stat.clr_last  = (clr_idx_reg == HIST_AW'(HIST_D - 1));
    assign stat.loaded    = loaded_reg;
    assign stat.want_emit = (pend_reg > lag);
    assign stat.win_empty = (r0 > r1) || (c0 > c1);
    assign stat.elem_last = elem_last_reg;
    assign stat.scan_last = (scan_idx_reg == SCAN_W'(HIST_D));
    assign stat.out_free  = !m_valid_reg || m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(1024);
            frame_height_reg <= CFG_W'(1024);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FRAME_WIDTH) frame_width_reg <= cfg_data;
            if (cfg_index == REG_FRAME_HEIGHT) frame_height_reg <= cfg_data;
        end
    end

    // frame positions, fill level and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_base_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_base_reg <= '0;
            pend_reg     <= '0;
            loaded_reg   <= 1'b0;
            clr_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_idx_reg <= clr_idx_reg + HIST_AW'(1);
            if (m_valid_reg && m_ready && !cmd.emit_done) m_valid_reg <= 1'b0;
            // advance the input position
            if (cmd.px_write) begin
                pend_reg <= pend_reg + PW'(1);
                if (in_col_reg + CW'(1) >= w) begin
                    in_col_reg <= '0;
                    if (in_row_reg + RW'(1) >= h) begin
                        in_row_reg  <= '0;
                        in_base_reg <= '0;
                        loaded_reg  <= 1'b1;
                    end else begin
                        in_row_reg  <= in_row_reg + RW'(1);
                        in_base_reg <= in_base_adv;
                    end
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            // hand off the result and advance the output position
            if (cmd.emit_done) begin
                m_valid_reg <= 1'b1;
                if (loaded_reg && out_row_n >= h) begin
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_base_reg <= '0;
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_base_reg  <= '0;
                    pend_reg     <= '0;
                    loaded_reg   <= 1'b0;
                end else begin
                    out_row_reg <= out_row_n;
                    out_col_reg <= out_col_n;
                    if (out_row_n != out_row_reg) out_base_reg <= out_base_adv;
                    pend_reg <= pend_reg - PW'(1);
                end
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_done) begin
            m_last_reg <= loaded_reg && (out_row_n >= h);
            for (int k = 0; k < 3; k++) begin
                m_pix_reg[k] <= med_reg[k];
            end
        end
    end

    // window iterator, gather and median scan
    always_ff @(posedge aclk) begin
        if (cmd.win_init) begin
            iter_row_reg <= r0;
            iter_col_reg <= c0;
            r1_reg       <= r1;
            c0_reg       <= c0;
            c1_reg       <= c1;
            row_addr_reg <= row_addr_init;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                acc_reg[k]   <= '0;
                med_reg[k]   <= '0;
                found_reg[k] <= 1'b0;
            end
        end
        if (cmd.store_rd) begin
            elem_last_reg <= (iter_row_reg == r1_reg) && (iter_col_reg == c1_reg);
            if (iter_col_reg == c1_reg) begin
                iter_col_reg <= c0_reg;
                iter_row_reg <= iter_row_reg + RW'(1);
                row_addr_reg <= row_addr_adv;
            end else begin
                iter_col_reg <= iter_col_reg + CW'(1);
            end
        end
        if (cmd.hist_rd) begin
            byte_reg[0] <= store_rdata[SW-1 -: PIX_W];
            byte_reg[1] <= store_rdata[PIX_W +: PIX_W];
            byte_reg[2] <= store_rdata[PIX_W-1:0];
        end
        if (cmd.hist_inc) count_reg <= count_reg + CNT_W'(1);
        if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + SCAN_W'(1);
            if (scan_idx_reg != '0) begin
                for (int k = 0; k < 3; k++) begin
                    logic [CNT_W:0] sum;
                    sum = (CNT_W+1)'(acc_reg[k]) + (CNT_W+1)'(hist_rdata[k]);
                    acc_reg[k] <= CNT_W'(sum);
                    if (!found_reg[k] && sum > (CNT_W+1)'(count_reg >> 1)) begin
                        found_reg[k] <= 1'b1;
                        med_reg[k]   <= PIX_W'(scan_idx_reg - SCAN_W'(1));
                    end
                end
            end
        end
    end

    // histogram port selection: clear, increment, or zero behind the scan
    assign hist_re = cmd.hist_rd || (cmd.scan_step && !stat.scan_last);
    assign hist_we = cmd.clr_step || cmd.hist_inc ||
                     (cmd.scan_step && (scan_idx_reg != '0));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hist_raddr[k] = scan_idx_reg[HIST_AW-1:0];
            hist_waddr[k] = HIST_AW'(scan_idx_reg - SCAN_W'(1));
            hist_wdata[k] = '0;
            priority if (cmd.clr_step) begin
                hist_waddr[k] = clr_idx_reg;
            end else if (cmd.hist_inc) begin
                hist_waddr[k] = byte_reg[k];
                hist_wdata[k] = hist_rdata[k] + CNT_W'(1);
            end
        end
        if (cmd.hist_rd) begin
            hist_raddr[0] = store_rdata[SW-1 -: PIX_W];
            hist_raddr[1] = store_rdata[PIX_W +: PIX_W];
            hist_raddr[2] = store_rdata[PIX_W-1:0];
        end
    end

    // line store
    rmf_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (cmd.px_write),
        .waddr (wr_addr),
        .wdata ({s_red_in, s_green_in, s_blue_in}),
        .re    (cmd.store_rd),
        .raddr (elem_addr),
        .rdata (store_rdata)
    );

    // per-channel histograms
    for (genvar g = 0; g < 3; g++) begin : g_hist
        rmf_ram #(
            .WIDTH (CNT_W),
            .DEPTH (HIST_D)
        ) u_hist (
            .clk   (aclk),
            .we    (hist_we),
            .waddr (hist_waddr[g]),
            .wdata (hist_wdata[g]),
            .re    (hist_re),
            .raddr (hist_raddr[g]),
            .rdata (hist_rdata[g])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_last = m_last_reg;
    assign m_red_out    = m_pix_reg[0];
    assign m_green_out  = m_pix_reg[1];
    assign m_blue_out   = m_pix_reg[2];

endmodule

/* test/rgb_median_filter_15x15_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_median_filter_15x15_tb: self-checking bench for the RGB median filter
// Loads whole frames of raster pixels, then drains them. A local model keeps
// its own line store and window counters, and predicts each median word.
// Frames run at many sizes, including zero register values and single rows
// and columns. Both handshake sides stall in random bursts, and the bench
// also holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module rgb_median_filter_15x15_tb;

    import rmf_pkg::*;

    localparam int MAXW  = 1024;
    localparam int MAXH  = 1024;
    localparam int RAD   = 7;
    localparam int DEPTH = (2 * RAD + 1) * MAXW;
    localparam int ITEMS = 1450;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } median_t;

    typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_EXTREME, FILL_RAMP} fill_e;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_action;
    logic [PIX_W-1:0] s_red_in;
    logic [PIX_W-1:0] s_green_in;
    logic [PIX_W-1:0] s_blue_in;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_red_out;
    logic [PIX_W-1:0] m_green_out;
    logic [PIX_W-1:0] m_blue_out;
    logic             m_frame_last;

    // model state
    logic [23:0]  pix_store [DEPTH];
    int unsigned  reg_width;
    int unsigned  reg_height;
    int unsigned  in_row, in_col, out_row, out_col;
    bit           loaded;
    bit           frame_closed;
    median_t      median_q [$];

    // run bookkeeping
    int  mismatches;
    int  words_sent;
    int  medians_seen;
    int  frames_run;
    bit  idle_on;
    int  hold_off;
    int  rx_gap;

    rgb_median_filter_15x15 u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_frame_last(m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #80_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] hist_median(input int hist [256], int cnt);
        int acc;
        acc = 0;
        if (cnt == 0) return 8'd0;
        for (int v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > cnt / 2) return v[7:0];
        end
        return 8'd255;
    endfunction

    // Compute the window medians at the output position, then advance it.
    function automatic void push_window_median(int unsigned w, int unsigned h);
        int      hr [256];
        int      hg [256];
        int      hb [256];
        int      r0, r1, c0, c1, cnt;
        logic [23:0] px;
        median_t m;
        foreach (hr[i]) begin
            hr[i] = 0;
            hg[i] = 0;
            hb[i] = 0;
        end
        cnt = 0;
        r0 = int'(out_row) - RAD;
        r1 = int'(out_row) + RAD;
        c0 = int'(out_col) - RAD;
        c1 = int'(out_col) + RAD;
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r1 > int'(h) - 1) r1 = int'(h) - 1;
        if (c1 > int'(w) - 1) c1 = int'(w) - 1;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                px = pix_store[(r * int'(w) + c) % DEPTH];
                hr[px[23:16]]++;
                hg[px[15:8]]++;
                hb[px[7:0]]++;
                cnt++;
            end
        end
        m.red   = hist_median(hr, cnt);
        m.green = hist_median(hg, cnt);
        m.blue  = hist_median(hb, cnt);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        m.last = loaded && (out_row >= h);
        if (m.last) begin
            out_row = 0;
            out_col = 0;
            in_row = 0;
            in_col = 0;
            loaded = 1'b0;
            frame_closed = 1'b1;
        end
        median_q.push_back(m);
    endfunction

    // Advance the model by one accepted word.
    function automatic void model_word(logic act, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
        int unsigned w, h, avail;
        w = clamp_dim(reg_width, MAXW);
        h = clamp_dim(reg_height, MAXH);
        if (act == ACT_DRAIN) begin
            if (loaded) push_window_median(w, h);
            return;
        end
        if (loaded) return;
        if (in_row >= h) in_row = h - 1;
        if (in_col >= w) in_col = w - 1;
        pix_store[(in_row * w + in_col) % DEPTH] = {r, g, b};
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
                in_row = 0;
                loaded = 1'b1;
            end
        end
        avail = loaded ? w * h : in_row * w + in_col;
        if (avail > out_row * w + out_col + RAD * w + RAD) push_window_median(w, h);
    endfunction

    // Drive one word and hold it until the block takes it.
    task automatic send_word(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_action   <= act;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        model_word(act, r, g, b);
        words_sent++;
    endtask

    // Send a word with a random payload.
    task automatic send_random(logic act);
        send_word(act, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx == REG_FRAME_WIDTH) reg_width = val;
        else reg_height = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pause the sender until every expected median has arrived.
    task automatic wait_drained();
        go_quiet();
        while (median_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Load one frame, then drain it; noise words are ones the block ignores.
    task automatic run_frame(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv, fill_e fill,
                             bit noise, bit mid_pause);
        int unsigned w, h, n;
        logic [7:0] r, g, b;
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        w = clamp_dim(wv, MAXW);
        h = clamp_dim(hv, MAXH);
        frame_closed = 1'b0;
        for (n = 0; n < w * h; n++) begin
            case (fill)
                FILL_FLAT:    {r, g, b} = {3{8'hA5}};
                FILL_EXTREME: {r, g, b} = n[0] ? 24'hFF00FF : 24'h00FF00;
                FILL_RAMP:    {r, g, b} = {n[7:0], ~n[7:0], n[9:2]};
                default:      {r, g, b} = 24'($urandom);
            endcase
            if (noise && $urandom_range(0, 9) == 0)
                send_random(ACT_DRAIN);
            if (mid_pause && n == w * h / 2) wait_drained();
            send_word(ACT_PIXEL, r, g, b);
        end
        while (!frame_closed) begin
            if (noise && $urandom_range(0, 9) == 0)
                send_random(ACT_PIXEL);
            send_random(ACT_DRAIN);
        end
        frames_run++;
        wait_drained();
    endtask

    task automatic test_small_directed();
        run_frame(11'd1, 11'd1, FILL_EXTREME, 1'b0, 1'b0);
        run_frame(11'd0, 11'd1, FILL_RANDOM, 1'b1, 1'b0);
        run_frame(11'd2, 11'd2, FILL_RANDOM, 1'b0, 1'b0);
        run_frame(11'd3, 11'd1, FILL_EXTREME, 1'b1, 1'b0);
        run_frame(11'd4, 11'd4, FILL_RAMP, 1'b0, 1'b0);
    endtask

    // interior windows of full size and the flat image
    task automatic test_full_window();
        run_frame(11'd16, 11'd16, FILL_RANDOM, 1'b0, 1'b0);
        run_frame(11'd8, 11'd8, FILL_FLAT, 1'b0, 1'b0);
    endtask

    // degenerate shapes: zero size registers, one column, one row
    task automatic test_size_extremes();
        run_frame(11'd0, 11'd0, FILL_RAMP, 1'b0, 1'b0);
        run_frame(11'd1, 11'd40, FILL_RANDOM, 1'b0, 1'b0);
        run_frame(11'd40, 11'd1, FILL_EXTREME, 1'b0, 1'b0);
    endtask

    // stall the output long enough for the input to back up
    task automatic test_backpressure();
        hold_off = 3000;
        run_frame(11'd9, 11'd9, FILL_RANDOM, 1'b0, 1'b0);
        run_frame(11'd12, 11'd10, FILL_RANDOM, 1'b1, 1'b1);
    endtask

    // random frames until the word count reaches stop_at
    task automatic test_random_frames(int stop_at);
        logic [CFG_W-1:0] wv, hv;
        fill_e            fill;
        bit               noise;
        while (words_sent < stop_at) begin
            wv = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                    : $urandom_range(1, 9));
            hv = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                    : $urandom_range(1, 9));
            fill = ($urandom_range(0, 5) == 0) ? fill_e'($urandom_range(1, 3))
                                               : FILL_RANDOM;
            noise = ($urandom_range(0, 2) == 0);
            run_frame(wv, hv, fill, noise, 1'b0);
        end
    endtask

    // output side: random stalls and the long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap  <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge aclk) begin
        median_t want;
        if (aresetn && m_valid && m_ready) begin
            medians_seen++;
            if (median_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected median word %0d", medians_seen);
            end else begin
                want = median_q.pop_front();
                if (want != {m_red_out, m_green_out, m_blue_out, m_frame_last}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d: expected r=%0d g=%0d b=%0d last=%0d, ",
                                  "got r=%0d g=%0d b=%0d last=%0d"},
                                 medians_seen, want.red, want.green, want.blue,
                                 want.last, m_red_out, m_green_out, m_blue_out,
                                 m_frame_last);
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_action   = ACT_PIXEL;
        s_red_in   = '0;
        s_green_in = '0;
        s_blue_in  = '0;
        m_ready    = 1'b0;
        reg_width  = 1024;
        reg_height = 1024;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        loaded = 1'b0;
        mismatches = 0; words_sent = 0; medians_seen = 0; frames_run = 0;
        hold_off = 0; rx_gap = 0;
        idle_on = 1'b1;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_small_directed();
        test_full_window();
        test_backpressure();
        test_size_extremes();
        test_random_frames(ITEMS - 200);
        idle_on = 1'b0;
        test_random_frames(ITEMS);

        while (median_q.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
        $display("Ran %0d frames: %0d words in, %0d median words checked.",
                 frames_run, words_sent, medians_seen);
        $display("Sizes 1x1 to 40 wide or tall, with long output stalls and ignored words.");
        if (mismatches == 0 && median_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, median_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* rgb_median_filter_15x15.f */
hdl/rmf_pkg.sv
hdl/rmf_ram.sv
hdl/rmf_ctrl.sv
hdl/rmf_datapath.sv
hdl/rgb_median_filter_15x15.sv
test/rgb_median_filter_15x15_tb.sv
